// ----- hw/rtl/gibs_pkg.sv -----
package gibs_pkg;

  typedef struct packed {
    logic signed [15:0] x_min;
    logic signed [15:0] y_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_max;
    logic        [15:0] score;
    logic               last_box;
  } box_in_t;

  typedef struct packed {
    logic        [15:0] box_index;
    logic signed [15:0] kept_x_min;
    logic signed [15:0] kept_y_min;
    logic signed [15:0] kept_x_max;
    logic signed [15:0] kept_y_max;
    logic        [15:0] kept_score;
    logic               valid_res;
    logic               overflow;
    logic               last_result;
  } box_out_t;

  // entry passed from the loader to the suppression engine
  typedef struct packed {
    logic [63:0] box;
    logic [15:0] score;
    logic [15:0] index;
  } entry_t;

  localparam logic [15:0] IouThrReset = 16'd26214;
  localparam int unsigned RegIouThr = 0;

endpackage

// ----- hw/rtl/gibs_if.sv -----
interface gibs_in_if;
  logic valid;
  logic ready;
  gibs_pkg::box_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gibs_out_if;
  logic valid;
  logic ready;
  gibs_pkg::box_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/greedy_iou_box_suppression.sv -----
// channel   dir  beat contents
// in_if     in   box corners, score, last_box
// out_if    out  kept box with index, score, flags
// cfg       in   apb, reg 0 = iou_threshold at 0x0
//
// load: each box is shifted in one entry at a time until it reaches the front or stops
// behind a stored box of equal or higher score; a box that arrives when full is dropped
// set end: at most n*(n-1)/2 pair tests (read, geometry, multiply, compare), then one result per kept box
// reset clears control state, threshold to 0.4; the store needs no clearing
// output register lets the engine stall on its own; loader waits during suppression
module greedy_iou_box_suppression #(
  parameter int unsigned MAX_DETS   = 64,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  gibs_in_if.sink    in_if,
  gibs_out_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gibs_pkg::*;
  localparam int unsigned AW = $clog2(MAX_DETS);
  localparam int unsigned CW = $clog2(MAX_DETS + 1);

  logic [15:0]   thr_q;
  logic          set_valid, set_ready, set_ovf;
  logic [CW-1:0] set_count;
  logic [AW-1:0] rd_addr;
  entry_t        rd_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'(RegIouThr)) ? {16'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= IouThrReset;
    else if (psel && penable && pwrite && paddr == 1'(RegIouThr)) thr_q <= pwdata[15:0];
  end

  gibs_loader #(.MaxDets(MAX_DETS), .IndexBits(INDEX_BITS)) u_loader (
    .clk_i, .rst_ni, .in_if,
    .set_valid_o(set_valid), .set_ready_i(set_ready),
    .set_count_o(set_count), .set_ovf_o(set_ovf),
    .rd_addr_i(rd_addr), .rd_data_o(rd_data)
  );

  gibs_engine #(.MaxDets(MAX_DETS)) u_engine (
    .clk_i, .rst_ni, .thr_i(thr_q),
    .set_valid_i(set_valid), .set_ready_o(set_ready),
    .set_count_i(set_count), .set_ovf_i(set_ovf),
    .rd_addr_o(rd_addr), .rd_data_i(rd_data), .out_if
  );

  a_no_in_during_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_valid |-> !in_if.ready) else $error("input taken during suppression");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.data.valid_res |-> out_if.data.last_result)
    else $error("empty result not last");
endmodule

// ----- hw/rtl/gibs_loader.sv -----
// front part: sorted insertion, one shift step at a time; no new box is taken until the last is placed
module gibs_loader #(
  parameter int unsigned MaxDets   = 64,
  parameter int unsigned IndexBits = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  gibs_in_if.sink in_if,
  // set hand-off to the engine
  output logic              set_valid_o,
  input  logic              set_ready_i,
  output logic [$clog2(MaxDets+1)-1:0] set_count_o,
  output logic              set_ovf_o,
  // engine reads the store
  input  logic [$clog2(MaxDets)-1:0] rd_addr_i,
  output gibs_pkg::entry_t  rd_data_o
);
  import gibs_pkg::*;
  localparam int unsigned AW = $clog2(MaxDets);
  localparam int unsigned CW = $clog2(MaxDets + 1);

  localparam logic [1:0] SIdle = 2'd0, SShift = 2'd1, SHand = 2'd2;

  entry_t mem [MaxDets];
  logic [1:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [15:0]   icnt_q, icnt_d;
  logic          ovf_q, ovf_d, last_q, last_d;
  entry_t        new_q, new_d;
  entry_t        rd_q;
  logic [AW-1:0] raddr;
  logic          wr_en;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  assign in_if.ready = (st_q == SIdle);
  assign set_valid_o = (st_q == SHand);
  assign set_count_o = cnt_q;
  assign set_ovf_o   = ovf_q;
  assign rd_data_o   = rd_q;

  // read port shared: in shift state we read pos-1, otherwise the engine
  assign raddr = (st_q == SShift) ? pos_q - AW'(1) : rd_addr_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // shift walks down from cnt: each step reads pos-1, registered in rd_q and flagged by rd_ok_q in the next cycle
  logic rd_ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0; pos_q <= '0; icnt_q <= '0;
      ovf_q <= 1'b0; last_q <= 1'b0; rd_ok_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; pos_q <= pos_d; icnt_q <= icnt_d;
      ovf_q <= ovf_d; last_q <= last_d;
      rd_ok_q <= (st_q == SShift) && !rd_ok_q && (st_d == SShift);
    end
  end

  always_ff @(posedge clk_i) new_q <= new_d;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; pos_d = pos_q; icnt_d = icnt_q;
    ovf_d = ovf_q; last_d = last_q; new_d = new_q;
    wr_en = 1'b0; waddr = pos_q; wdata = new_q;
    unique case (st_q)
      SIdle: begin
        if (in_if.valid) begin
          icnt_d = icnt_q + 16'd1;
          last_d = in_if.data.last_box;
          new_d.box   = {in_if.data.y_max, in_if.data.x_max,
                         in_if.data.y_min, in_if.data.x_min};
          new_d.score = in_if.data.score;
          new_d.index = 16'(icnt_q[IndexBits-1:0]);
          if (cnt_q == CW'(MaxDets)) begin
            ovf_d = 1'b1;
            if (in_if.data.last_box) st_d = SHand;
          end else begin
            pos_d = AW'(cnt_q);
            st_d  = SShift;
          end
        end
      end
      SShift: begin
        if (pos_q == '0) begin
          wr_en = 1'b1; waddr = pos_q;
          cnt_d = cnt_q + CW'(1);
          st_d  = last_q ? SHand : SIdle;
        end else if (rd_ok_q) begin
          if (rd_q.score >= new_q.score) begin
            wr_en = 1'b1; waddr = pos_q;
            cnt_d = cnt_q + CW'(1);
            st_d  = last_q ? SHand : SIdle;
          end else begin
            wr_en = 1'b1; waddr = pos_q; wdata = rd_q;
            pos_d = pos_q - AW'(1);
          end
        end
      end
      SHand: begin
        if (set_ready_i) begin
          st_d = SIdle; cnt_d = '0; icnt_d = '0; ovf_d = 1'b0;
        end
      end
      default: st_d = SIdle;
    endcase
  end
endmodule

// ----- hw/rtl/gibs_engine.sv -----
// back part: greedy suppression, one pair test at a time, then emit
module gibs_engine #(
  parameter int unsigned MaxDets = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [15:0]       thr_i,
  input  logic              set_valid_i,
  output logic              set_ready_o,
  input  logic [$clog2(MaxDets+1)-1:0] set_count_i,
  input  logic              set_ovf_i,
  output logic [$clog2(MaxDets)-1:0] rd_addr_o,
  input  gibs_pkg::entry_t  rd_data_i,
  gibs_out_if.source out_if
);
  import gibs_pkg::*;
  localparam int unsigned AW = $clog2(MaxDets);
  localparam int unsigned CW = $clog2(MaxDets + 1);

  localparam logic [3:0] SIdle = 4'd0, SRdI = 4'd1, SWtI = 4'd2, SGetI = 4'd3,
                         SRdJ = 4'd4, SWtJ = 4'd5, SGeom = 4'd6, SMul = 4'd7,
                         SCmp = 4'd8, SERd = 4'd9, SEWt = 4'd10, SEOut = 4'd11,
                         SEmpty = 4'd12, SDone = 4'd13;

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] n_q, i_q, i_d, j_q, j_d;
  logic          ovf_q;
  logic [MaxDets-1:0] sup_q, sup_d;
  logic [63:0]   a_q, a_d;
  logic signed [16:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
  logic signed [33:0] inter_q, area_a_q, area_b_q;
  logic signed [35:0] uni;
  logic signed [51:0] lhs, rhs;
  logic          out_v_q, out_v_d;
  box_out_t      out_q, out_d;
  logic          emit_last;

  function automatic logic signed [16:0] c(input logic [63:0] b, input int k);
    return 17'(signed'(b[16*k +: 16]));
  endfunction

  assign set_ready_o = (st_q == SDone);
  assign out_if.valid = out_v_q;
  assign out_if.data  = out_q;
  assign rd_addr_o = (st_q == SRdI || st_q == SWtI || st_q == SERd ||
                      st_q == SEWt || st_q == SEOut) ? AW'(i_q) : AW'(j_q);

  // geometry register stage
  logic signed [16:0] ix0, iy0, ix1, iy1, dw, dh;
  logic [63:0] b;
  always_comb begin
    b   = rd_data_i.box;
    ix0 = (c(a_q,0) > c(b,0)) ? c(a_q,0) : c(b,0);
    iy0 = (c(a_q,1) > c(b,1)) ? c(a_q,1) : c(b,1);
    ix1 = (c(a_q,2) < c(b,2)) ? c(a_q,2) : c(b,2);
    iy1 = (c(a_q,3) < c(b,3)) ? c(a_q,3) : c(b,3);
    dw  = ix1 - ix0;
    dh  = iy1 - iy0;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SGeom) begin
      iw_q <= (dw > 0) ? dw : '0;
      ih_q <= (dh > 0) ? dh : '0;
      aw_q <= c(a_q,2) - c(a_q,0);
      ah_q <= c(a_q,3) - c(a_q,1);
      bw_q <= c(b,2) - c(b,0);
      bh_q <= c(b,3) - c(b,1);
    end
    if (st_q == SMul) begin
      inter_q  <= iw_q * ih_q;
      area_a_q <= aw_q * ah_q;
      area_b_q <= bw_q * bh_q;
    end
    a_q   <= a_d;
    out_q <= out_d;
  end

  assign uni = 36'(area_a_q) + 36'(area_b_q) - 36'(inter_q);
  assign lhs = 52'(inter_q) <<< 16;
  assign rhs = 52'(signed'({1'b0, thr_i})) * 52'(uni);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; n_q <= '0; i_q <= '0; j_q <= '0; ovf_q <= 1'b0;
      sup_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; i_q <= i_d; j_q <= j_d; sup_q <= sup_d; out_v_q <= out_v_d;
      if (st_q == SIdle && set_valid_i) begin
        n_q <= set_count_i; ovf_q <= set_ovf_i;
      end
    end
  end

  // emit_last is tied high; last_result is set when no unsuppressed index follows i
  assign emit_last = 1'b1;

  always_comb begin
    logic more;
    more = 1'b0;
    st_d = st_q; i_d = i_q; j_d = j_q; sup_d = sup_q; a_d = a_q;
    out_d = out_q;
    out_v_d = out_v_q && !out_if.ready;
    for (int k = 0; k < MaxDets; k++) begin
      if (CW'(k) > i_q && CW'(k) < n_q && !sup_q[k]) more = 1'b1;
    end
    unique case (st_q)
      SIdle: if (set_valid_i) begin
        sup_d = '0; i_d = '0;
        st_d = (set_count_i == '0) ? SEmpty : SRdI;
      end
      SRdI: begin
        if (i_q >= n_q) begin
          i_d = '0; st_d = SERd;
        end else if (sup_q[AW'(i_q)]) begin
          i_d = i_q + CW'(1);
        end else begin
          st_d = SWtI;
        end
      end
      SWtI: st_d = SGetI;
      SGetI: begin
        a_d = rd_data_i.box; j_d = i_q + CW'(1); st_d = SRdJ;
      end
      SRdJ: begin
        if (j_q >= n_q) begin
          i_d = i_q + CW'(1); st_d = SRdI;
        end else if (sup_q[AW'(j_q)]) begin
          j_d = j_q + CW'(1);
        end else begin
          st_d = SWtJ;
        end
      end
      SWtJ: st_d = SGeom;
      SGeom: st_d = SMul;
      SMul: st_d = SCmp;
      SCmp: begin
        if (uni <= 0 || lhs > rhs) sup_d[AW'(j_q)] = 1'b1;
        j_d = j_q + CW'(1); st_d = SRdJ;
      end
      SERd: begin
        if (i_q >= n_q) st_d = SDone;
        else if (sup_q[AW'(i_q)]) i_d = i_q + CW'(1);
        else st_d = SEWt;
      end
      SEWt: st_d = SEOut;
      SEOut: if (!out_v_q || out_if.ready) begin
        out_v_d = 1'b1;
        out_d.box_index  = rd_data_i.index;
        out_d.kept_x_min = rd_data_i.box[15:0];
        out_d.kept_y_min = rd_data_i.box[31:16];
        out_d.kept_x_max = rd_data_i.box[47:32];
        out_d.kept_y_max = rd_data_i.box[63:48];
        out_d.kept_score = rd_data_i.score;
        out_d.valid_res  = 1'b1;
        out_d.overflow   = ovf_q;
        out_d.last_result = emit_last && !more;
        i_d = i_q + CW'(1); st_d = SERd;
      end
      SEmpty: if (!out_v_q || out_if.ready) begin
        out_v_d = 1'b1;
        out_d = '0;
        out_d.overflow = set_ovf_i;
        out_d.last_result = 1'b1;
        st_d = SDone;
      end
      SDone: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end
endmodule
